// ----- hdl/frn_pkg.sv -----
// Shared types and constants for the fraction reduce/normalize block.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps

package frn_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  // Result status codes, carried on out_tuser
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Reduction core sequencer
  typedef enum logic [2:0] {
    C_IDLE,
    C_TWOS,
    C_GCD,
    C_DIVN,
    C_DIVD,
    C_DONE
  } core_state_t;

  // Top-level request flow
  typedef enum logic [1:0] {
    T_IDLE,
    T_CORE,
    T_PUSH
  } top_state_t;

  // Core status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } core_status_t;

endpackage

// ----- hdl/frn_sub.sv -----
// Shared subtract/compare unit of the reduction core.
// Depends on frn_pkg for its default width; instantiated by frn_core.
`timescale 1ns / 1ps

module frn_sub #(
  parameter int WIDTH = frn_pkg::DATA_WIDTH_DEF
) (
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  output logic [WIDTH-1:0] diff,
  output logic             borrow,
  output logic             zero
);

  logic [WIDTH:0] full;

  assign full   = {1'b0, x} - {1'b0, y};
  assign diff   = full[WIDTH-1:0];
  assign borrow = full[WIDTH];
  assign zero   = (full == '0);

endmodule

// ----- hdl/frn_core.sv -----
// Reduction core: binary GCD, then two restoring divisions, all on one
// shared subtractor (frn_sub). Uses frn_pkg for state and status types.
`timescale 1ns / 1ps

module frn_core #(
  parameter int DATA_WIDTH = frn_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DATA_WIDTH-2:0]    mag_num,
  input  logic [DATA_WIDTH-2:0]    mag_den,
  output frn_pkg::core_status_t    status,
  output logic [DATA_WIDTH-2:0]    red_num,
  output logic [DATA_WIDTH-2:0]    red_den
);

  localparam int MW = DATA_WIDTH - 1;
  localparam int KW = $clog2(MW + 1);
  localparam logic [KW-1:0] LAST = KW'(MW - 1);

  frn_pkg::core_state_t state_r, state_nxt;

  logic [MW-1:0] an_r, an_nxt;
  logic [MW-1:0] ad_r, ad_nxt;
  logic [MW-1:0] a_r, a_nxt;
  logic [MW-1:0] b_r, b_nxt;
  logic [MW-1:0] g_r, g_nxt;
  logic [MW-1:0] x_r, x_nxt;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [MW-1:0] rn_r, rn_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;

  logic [MW:0] su_x, su_y, su_diff;
  logic        su_borrow, su_zero;
  logic [MW-1:0] q_next;

  frn_sub #(.WIDTH(MW + 1)) u_sub (
    .x      (su_x),
    .y      (su_y),
    .diff   (su_diff),
    .borrow (su_borrow),
    .zero   (su_zero)
  );

  // Divide states feed the shifted partial remainder, others compare a to b
  always_comb begin
    if (state_r == frn_pkg::C_DIVN || state_r == frn_pkg::C_DIVD) begin
      su_x = {rem_r, x_r[MW-1]};
      su_y = {1'b0, g_r};
    end else begin
      su_x = {1'b0, a_r};
      su_y = {1'b0, b_r};
    end
  end

  assign q_next = {x_r[MW-2:0], ~su_borrow};

  always_comb begin
    state_nxt = state_r;
    an_nxt    = an_r;
    ad_nxt    = ad_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    g_nxt     = g_r;
    x_nxt     = x_r;
    rem_nxt   = rem_r;
    rn_nxt    = rn_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      frn_pkg::C_IDLE: begin
        if (start) begin
          an_nxt    = mag_num;
          ad_nxt    = mag_den;
          a_nxt     = mag_num;
          b_nxt     = mag_den;
          k_nxt     = '0;
          state_nxt = frn_pkg::C_TWOS;
        end
      end
      frn_pkg::C_TWOS: begin
        // strip common factors of two
        if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 1'b1;
        end else begin
          state_nxt = frn_pkg::C_GCD;
        end
      end
      frn_pkg::C_GCD: begin
        priority if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (su_zero) begin
          g_nxt     = a_r << k_r;
          x_nxt     = an_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = frn_pkg::C_DIVN;
        end else if (su_borrow) begin
          // a < b: swap so the next subtract goes the right way
          a_nxt = b_r;
          b_nxt = a_r;
        end else begin
          a_nxt = su_diff[MW:1];
        end
      end
      frn_pkg::C_DIVN, frn_pkg::C_DIVD: begin
        rem_nxt = su_borrow ? su_x[MW-1:0] : su_diff[MW-1:0];
        x_nxt   = q_next;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          if (state_r == frn_pkg::C_DIVN) begin
            rn_nxt    = q_next;
            x_nxt     = ad_r;
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = frn_pkg::C_DIVD;
          end else begin
            state_nxt = frn_pkg::C_DONE;
          end
        end
      end
      frn_pkg::C_DONE: begin
        state_nxt = frn_pkg::C_IDLE;
      end
      default: begin
        state_nxt = frn_pkg::C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frn_pkg::C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    an_r  <= an_nxt;
    ad_r  <= ad_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    g_r   <= g_nxt;
    x_r   <= x_nxt;
    rem_r <= rem_nxt;
    rn_r  <= rn_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
  end

  assign status.busy = (state_r != frn_pkg::C_IDLE);
  assign status.done = (state_r == frn_pkg::C_DONE);
  assign red_num     = rn_r;
  assign red_den     = x_r;

endmodule

// ----- hdl/fraction_reduce_normalize.sv -----
// Top level: stream handshake, special cases, sign handling, result register.
// Depends on frn_pkg, frn_core (which uses frn_sub).
`timescale 1ns / 1ps
//
//  channel | dir | ports                          | contents (low bit up)
//  --------+-----+--------------------------------+-----------------------------------
//  in_     | in  | in_tvalid/in_tready/in_tdata   | numerator, denominator
//  out_    | out | out_tvalid/out_tready/out_tdata| reduced_numerator, reduced_denominator
//          |     | out_tuser                      | status
//
//  Zero denominator, most negative value and zero numerator skip the core: the
//  result is registered as pending, then moved to the output register. Other
//  requests run in the core: common-twos strip, binary GCD on one shared
//  subtractor, then two restoring divisions of DATA_WIDTH-1 bits each. One request
//  at a time; in_tready is high only idle. A finished result waits in the output
//  register while out_tready is low.
//  Reset: synchronous, active low; clears control state only.

module fraction_reduce_normalize #(
  parameter int DATA_WIDTH = frn_pkg::DATA_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // numerator [W-1:0], denominator [2W-1:W], zero pad above
  input  logic [8*((2*DATA_WIDTH+7)/8)-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // reduced_numerator [W-1:0], reduced_denominator [2W-2:W], zero pad above
  output logic [8*((2*DATA_WIDTH-1+7)/8)-1:0]   out_tdata,
  // status [1:0]
  output logic [1:0]                            out_tuser
);

  localparam int W      = DATA_WIDTH;
  localparam int MW     = W - 1;
  localparam int OUT_DW = 8 * ((2 * W - 1 + 7) / 8);
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};

  frn_pkg::top_state_t   state_r, state_nxt;
  frn_pkg::core_status_t core_st;

  logic [W-1:0]  in_num, in_den, in_num_abs, in_den_abs;
  logic          in_acc, normal;
  logic [MW-1:0] core_num, core_den;

  logic            neg_r, neg_nxt;
  logic [W-1:0]    pend_num_r, pend_num_nxt;
  logic [MW-1:0]   pend_den_r, pend_den_nxt;
  frn_pkg::status_t pend_st_r, pend_st_nxt;
  logic            out_tvalid_r, out_tvalid_nxt;
  logic [W-1:0]    out_num_r, out_num_nxt;
  logic [MW-1:0]   out_den_r, out_den_nxt;
  frn_pkg::status_t out_st_r, out_st_nxt;

  assign in_num     = in_tdata[W-1:0];
  assign in_den     = in_tdata[2*W-1:W];
  assign in_num_abs = in_num[W-1] ? (~in_num + 1'b1) : in_num;
  assign in_den_abs = in_den[W-1] ? (~in_den + 1'b1) : in_den;
  assign in_tready  = (state_r == frn_pkg::T_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign normal     = (in_den != '0) && (in_num != MOST_NEG) && (in_den != MOST_NEG)
                      && (in_num != '0);

  frn_core #(.DATA_WIDTH(DATA_WIDTH)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc && normal),
    .mag_num (in_num_abs[MW-1:0]),
    .mag_den (in_den_abs[MW-1:0]),
    .status  (core_st),
    .red_num (core_num),
    .red_den (core_den)
  );

  always_comb begin
    state_nxt      = state_r;
    neg_nxt        = neg_r;
    pend_num_nxt   = pend_num_r;
    pend_den_nxt   = pend_den_r;
    pend_st_nxt    = pend_st_r;
    out_num_nxt    = out_num_r;
    out_den_nxt    = out_den_r;
    out_st_nxt     = out_st_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    unique case (state_r)
      frn_pkg::T_IDLE: begin
        if (in_acc) begin
          neg_nxt      = in_num[W-1] ^ in_den[W-1];
          pend_num_nxt = '0;
          pend_den_nxt = '0;
          pend_st_nxt  = frn_pkg::ST_OK;
          // zero denominator wins over overflow; zero numerator gives 0/1
          priority if (in_den == '0) begin
            pend_st_nxt = frn_pkg::ST_ZERO_DEN;
            state_nxt   = frn_pkg::T_PUSH;
          end else if (in_num == MOST_NEG || in_den == MOST_NEG) begin
            pend_st_nxt = frn_pkg::ST_OVERFLOW;
            state_nxt   = frn_pkg::T_PUSH;
          end else if (in_num == '0) begin
            pend_den_nxt = MW'(1);
            state_nxt    = frn_pkg::T_PUSH;
          end else begin
            state_nxt = frn_pkg::T_CORE;
          end
        end
      end
      frn_pkg::T_CORE: begin
        if (core_st.done) begin
          pend_num_nxt = neg_r ? (~{1'b0, core_num} + 1'b1) : {1'b0, core_num};
          pend_den_nxt = core_den;
          pend_st_nxt  = frn_pkg::ST_OK;
          state_nxt    = frn_pkg::T_PUSH;
        end
      end
      frn_pkg::T_PUSH: begin
        if (!out_tvalid_r || out_tready) begin
          out_num_nxt    = pend_num_r;
          out_den_nxt    = pend_den_r;
          out_st_nxt     = pend_st_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = frn_pkg::T_IDLE;
        end
      end
      default: begin
        state_nxt = frn_pkg::T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= frn_pkg::T_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    pend_num_r <= pend_num_nxt;
    pend_den_r <= pend_den_nxt;
    pend_st_r  <= pend_st_nxt;
    out_num_r  <= out_num_nxt;
    out_den_r  <= out_den_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DW'({out_den_r, out_num_r});
  assign out_tuser  = out_st_r;

`ifndef SYNTH
  // one request in flight: no accept right after an accept
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("request accepted while busy");

  // error results carry 0/0
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_st_r != frn_pkg::ST_OK) |-> (out_num_r == '0 && out_den_r == '0))
    else $error("error result with nonzero payload");

  // good results always have a nonzero denominator
  a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_st_r == frn_pkg::ST_OK) |-> (out_den_r != '0))
    else $error("ok result with zero denominator");

  // core finishes only while the top waits on it
  a_core_done: assert property (@(posedge clk) disable iff (!rst_n)
    core_st.done |-> (state_r == frn_pkg::T_CORE))
    else $error("core done outside core wait");

  // core is idle whenever the top is idle
  a_core_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == frn_pkg::T_IDLE) |-> !core_st.busy)
    else $error("core busy while top idle");
`endif

endmodule
